// File: src/mp2d_pkg.sv
`default_nettype none
package mp2d_pkg;

	localparam int CFG_DATA_W = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int POS_W      = 9;
	localparam int PROD_W     = POS_W + 3;
	localparam int IDX_BITS   = 8;
	localparam int REM_W      = 2;
	localparam int FACT_W     = 3;

	localparam logic [FACT_W-1:0] MAX_STRIDE = 3'd4;

	localparam logic [POS_W-1:0]  RST_MAP_WIDTH   = 9'd256;
	localparam logic [POS_W-1:0]  RST_MAP_HEIGHT  = 9'd256;
	localparam logic [FACT_W-1:0] RST_POOL_STRIDE = 3'd2;
	localparam logic [FACT_W-1:0] RST_WINDOW_SIZE = 3'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAP_WIDTH   = 2'd0,
		REG_MAP_HEIGHT  = 2'd1,
		REG_POOL_STRIDE = 2'd2,
		REG_WINDOW_SIZE = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic ok;
		logic org;
		logic done;
		logic last;
	} lane_t;

	typedef struct packed {
		logic accept;
		logic rd_en;
		logic upd_fire;
	} cmd_t;

	typedef struct packed {
		logic pair_any;
		logic last_pair;
		logic completes;
		logic out_full;
		logic out_ready;
	} status_t;

endpackage
`default_nettype wire

// File: src/mp2d_if.sv
`default_nettype none
interface mp2d_in_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface mp2d_out_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                                valid;
	logic                                ready;
	logic signed [SAMPLE_BITS-1:0]       pooled_max;
	logic [mp2d_pkg::IDX_BITS-1:0]       out_row;
	logic [mp2d_pkg::IDX_BITS-1:0]       out_col;
	logic                                last_in_map;
	logic                                last_of_item;

	modport source (output valid, output pooled_max, output out_row, output out_col,
		output last_in_map, output last_of_item, input ready);
	modport sink (input valid, input pooled_max, input out_row, input out_col,
		input last_in_map, input last_of_item, output ready);
endinterface
`default_nettype wire

// File: src/mp2d_ctrl.sv
`default_nettype none
module mp2d_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire mp2d_pkg::status_t st,
	output mp2d_pkg::cmd_t         cmd,
	output logic                   in_ready
);

	mp2d_pkg::state_t state_q;
	mp2d_pkg::state_t state_next;
	logic             upd_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mp2d_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// outputs
	always_comb begin
		upd_ok       = !st.completes || !st.out_full || st.out_ready;
		in_ready     = 1'b0;
		cmd.rd_en    = 1'b0;
		cmd.upd_fire = 1'b0;
		unique case (state_q)
			mp2d_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			mp2d_pkg::ST_READ: begin
				cmd.rd_en = 1'b1;
			end
			mp2d_pkg::ST_UPDATE: begin
				cmd.upd_fire = upd_ok;
				in_ready     = upd_ok && st.last_pair;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
		cmd.accept = in_valid && in_ready;
	end

	// next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			mp2d_pkg::ST_IDLE: begin
				if (cmd.accept && st.pair_any) begin
					state_next = mp2d_pkg::ST_READ;
				end
			end
			mp2d_pkg::ST_READ: begin
				state_next = mp2d_pkg::ST_UPDATE;
			end
			mp2d_pkg::ST_UPDATE: begin
				if (cmd.upd_fire) begin
					if (!st.last_pair) begin
						state_next = mp2d_pkg::ST_READ;
					end else if (cmd.accept && st.pair_any) begin
						state_next = mp2d_pkg::ST_READ;
					end else begin
						state_next = mp2d_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_next = mp2d_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: src/mp2d_datapath.sv
`default_nettype none
module mp2d_datapath #(
	parameter int MAX_WIDTH   = 256,
	parameter int MAX_HEIGHT  = 256,
	parameter int MAX_WINDOW  = 4,
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [mp2d_pkg::CFG_IDX_W-1:0]        cfg_idx,
	input  wire logic [mp2d_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  wire logic signed [SAMPLE_BITS-1:0]         sample,
	input  wire mp2d_pkg::cmd_t                        cmd,
	output mp2d_pkg::status_t                          st,
	input  wire logic                                  out_ready,
	output logic                                       out_valid,
	output logic signed [SAMPLE_BITS-1:0]              pooled_max,
	output logic [mp2d_pkg::IDX_BITS-1:0]              out_row,
	output logic [mp2d_pkg::IDX_BITS-1:0]              out_col,
	output logic                                       last_in_map,
	output logic                                       last_of_item
);

	localparam int POS_W     = mp2d_pkg::POS_W;
	localparam int PROD_W    = mp2d_pkg::PROD_W;
	localparam int REM_W     = mp2d_pkg::REM_W;
	localparam int FACT_W    = mp2d_pkg::FACT_W;
	localparam int IDX_BITS  = mp2d_pkg::IDX_BITS;
	localparam int LANE_BITS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int COL_BITS  = $clog2(MAX_WIDTH);
	localparam int ADDR_W    = LANE_BITS + COL_BITS;
	localparam int DEPTH     = 2 ** ADDR_W;

	function automatic mp2d_pkg::lane_t lane_flags(
		input logic [POS_W-1:0]  pos,
		input logic [POS_W-1:0]  quo,
		input logic [REM_W-1:0]  rem,
		input logic [FACT_W-1:0] s,
		input logic [FACT_W-1:0] ksz,
		input logic [POS_W-1:0]  dim,
		input int                t
	);
		mp2d_pkg::lane_t    f;
		logic [PROD_W-1:0]  org;
		logic [PROD_W-1:0]  endp;
		logic [PROD_W-1:0]  posp;
		logic [PROD_W-1:0]  dimp;
		logic [PROD_W-1:0]  sp;
		org    = PROD_W'(pos) - PROD_W'(rem) - PROD_W'(t) * PROD_W'(s);
		sp     = PROD_W'(s);
		endp   = org + PROD_W'(ksz) - PROD_W'(1);
		posp   = PROD_W'(pos);
		dimp   = PROD_W'(dim);
		f.ok   = (quo >= POS_W'(t)) && (endp >= posp) && (org + sp <= dimp);
		f.org  = (org == posp);
		f.done = (endp >= dimp - PROD_W'(1)) ? (posp == dimp - PROD_W'(1)) : (posp == endp);
		f.last = (org + sp + sp > dimp);
		return f;
	endfunction

	function automatic logic [LANE_BITS-1:0] top_lane(input logic [MAX_WINDOW-1:0] m);
		logic [LANE_BITS-1:0] idx;
		idx = '0;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			if (m[i]) begin
				idx = LANE_BITS'(i);
			end
		end
		return idx;
	endfunction

	// configuration
	logic [POS_W-1:0]  map_width_q;
	logic [POS_W-1:0]  map_height_q;
	logic [FACT_W-1:0] pool_stride_q;
	logic [FACT_W-1:0] window_size_q;
	logic [POS_W-1:0]  w_eff;
	logic [POS_W-1:0]  h_eff;
	logic [FACT_W-1:0] s_eff;
	logic [FACT_W-1:0] k_eff;

	// raster position
	logic [POS_W-1:0] row_q;
	logic [POS_W-1:0] col_q;
	logic [POS_W-1:0] rq_q;
	logic [POS_W-1:0] cq_q;
	logic [REM_W-1:0] rr_q;
	logic [REM_W-1:0] cr_q;

	mp2d_pkg::lane_t       row_lane [MAX_WINDOW];
	mp2d_pkg::lane_t       col_lane [MAX_WINDOW];
	logic [MAX_WINDOW-1:0] jok;
	logic [MAX_WINDOW-1:0] jorg;
	logic [MAX_WINDOW-1:0] jdone;
	logic [MAX_WINDOW-1:0] jlast;
	logic [MAX_WINDOW-1:0] kok;
	logic [MAX_WINDOW-1:0] korg;
	logic [MAX_WINDOW-1:0] kdone;
	logic [MAX_WINDOW-1:0] klast;

	// current item
	logic [MAX_WINDOW-1:0]         jorg_q;
	logic [MAX_WINDOW-1:0]         jdone_q;
	logic [MAX_WINDOW-1:0]         jlast_q;
	logic [MAX_WINDOW-1:0]         kmask_q;
	logic [MAX_WINDOW-1:0]         korg_q;
	logic [MAX_WINDOW-1:0]         kdone_q;
	logic [MAX_WINDOW-1:0]         klast_q;
	logic [MAX_WINDOW-1:0]         jrem_q;
	logic [MAX_WINDOW-1:0]         krem_q;
	logic [POS_W-1:0]              rq_item_q;
	logic [POS_W-1:0]              cq_item_q;
	logic signed [SAMPLE_BITS-1:0] x_q;

	logic [LANE_BITS-1:0]          ti;
	logic [LANE_BITS-1:0]          tk;
	logic [POS_W-1:0]              j_cur;
	logic [POS_W-1:0]              k_cur;
	logic [ADDR_W-1:0]             addr;
	logic [MAX_WINDOW-1:0]         krem_next;
	logic [MAX_WINDOW-1:0]         jrem_after;
	logic                          completes;
	logic                          later_done;
	logic signed [SAMPLE_BITS-1:0] new_val;

	// window store
	logic signed [SAMPLE_BITS-1:0] partial_max_q [DEPTH];
	logic signed [SAMPLE_BITS-1:0] rd_q;

	// result register
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] pooled_q;
	logic [IDX_BITS-1:0]           orow_q;
	logic [IDX_BITS-1:0]           ocol_q;
	logic                          olast_map_q;
	logic                          olast_item_q;

	always_comb begin
		w_eff = (map_width_q == '0) ? POS_W'(1) :
			(32'(map_width_q) > MAX_WIDTH) ? POS_W'(MAX_WIDTH) : map_width_q;
		h_eff = (map_height_q == '0) ? POS_W'(1) :
			(32'(map_height_q) > MAX_HEIGHT) ? POS_W'(MAX_HEIGHT) : map_height_q;
		s_eff = (pool_stride_q == '0) ? FACT_W'(1) :
			(pool_stride_q > mp2d_pkg::MAX_STRIDE) ? mp2d_pkg::MAX_STRIDE : pool_stride_q;
		k_eff = (window_size_q == '0) ? FACT_W'(1) :
			(32'(window_size_q) > MAX_WINDOW) ? FACT_W'(MAX_WINDOW) : window_size_q;
	end

	// open windows that cover the next sample, one lane per candidate
	always_comb begin
		for (int t = 0; t < MAX_WINDOW; t++) begin
			row_lane[t] = lane_flags(row_q, rq_q, rr_q, s_eff, k_eff, h_eff, t);
			col_lane[t] = lane_flags(col_q, cq_q, cr_q, s_eff, k_eff, w_eff, t);
			jok[t]      = row_lane[t].ok;
			jorg[t]     = row_lane[t].org;
			jdone[t]    = row_lane[t].done;
			jlast[t]    = row_lane[t].last;
			kok[t]      = col_lane[t].ok;
			korg[t]     = col_lane[t].org;
			kdone[t]    = col_lane[t].done;
			klast[t]    = col_lane[t].last;
		end
	end

	always_comb begin
		ti         = top_lane(jrem_q);
		tk         = top_lane(krem_q);
		j_cur      = rq_item_q - POS_W'(ti);
		k_cur      = cq_item_q - POS_W'(tk);
		addr       = {j_cur[LANE_BITS-1:0], COL_BITS'(k_cur)};
		krem_next  = krem_q & ~(MAX_WINDOW'(1) << tk);
		jrem_after = jrem_q & ~(MAX_WINDOW'(1) << ti);
		completes  = jdone_q[ti] && kdone_q[tk];
		later_done = (jdone_q[ti] && |(krem_next & kdone_q)) ||
			(|(jrem_after & jdone_q) && |(kmask_q & kdone_q));
		if (jorg_q[ti] && korg_q[tk]) begin
			new_val = x_q;
		end else begin
			new_val = (x_q > rd_q) ? x_q : rd_q;
		end
	end

	always_comb begin
		st.pair_any  = |jok && |kok;
		st.last_pair = (krem_next == '0) && (jrem_after == '0);
		st.completes = completes;
		st.out_full  = out_valid_q;
		st.out_ready = out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q   <= mp2d_pkg::RST_MAP_WIDTH;
			map_height_q  <= mp2d_pkg::RST_MAP_HEIGHT;
			pool_stride_q <= mp2d_pkg::RST_POOL_STRIDE;
			window_size_q <= mp2d_pkg::RST_WINDOW_SIZE;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				mp2d_pkg::REG_MAP_WIDTH:   map_width_q   <= cfg_data;
				mp2d_pkg::REG_MAP_HEIGHT:  map_height_q  <= cfg_data;
				mp2d_pkg::REG_POOL_STRIDE: pool_stride_q <= cfg_data[FACT_W-1:0];
				mp2d_pkg::REG_WINDOW_SIZE: window_size_q <= cfg_data[FACT_W-1:0];
				default: map_width_q <= map_width_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			rq_q  <= '0;
			cq_q  <= '0;
			rr_q  <= '0;
			cr_q  <= '0;
		end else if (cfg_we) begin
			row_q <= '0;
			col_q <= '0;
			rq_q  <= '0;
			cq_q  <= '0;
			rr_q  <= '0;
			cr_q  <= '0;
		end else if (cmd.accept) begin
			if (col_q + POS_W'(1) >= w_eff) begin
				col_q <= '0;
				cq_q  <= '0;
				cr_q  <= '0;
				if (row_q + POS_W'(1) >= h_eff) begin
					row_q <= '0;
					rq_q  <= '0;
					rr_q  <= '0;
				end else begin
					row_q <= row_q + POS_W'(1);
					if ({1'b0, rr_q} + FACT_W'(1) == s_eff) begin
						rr_q <= '0;
						rq_q <= rq_q + POS_W'(1);
					end else begin
						rr_q <= rr_q + REM_W'(1);
					end
				end
			end else begin
				col_q <= col_q + POS_W'(1);
				if ({1'b0, cr_q} + FACT_W'(1) == s_eff) begin
					cr_q <= '0;
					cq_q <= cq_q + POS_W'(1);
				end else begin
					cr_q <= cr_q + REM_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jrem_q <= '0;
			krem_q <= '0;
		end else if (cmd.accept) begin
			jrem_q <= jok;
			krem_q <= kok;
		end else if (cmd.upd_fire) begin
			if (krem_next == '0) begin
				jrem_q <= jrem_after;
				krem_q <= kmask_q;
			end else begin
				krem_q <= krem_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			jorg_q    <= jorg;
			jdone_q   <= jdone;
			jlast_q   <= jlast;
			kmask_q   <= kok;
			korg_q    <= korg;
			kdone_q   <= kdone;
			klast_q   <= klast;
			rq_item_q <= rq_q;
			cq_item_q <= cq_q;
			x_q       <= sample;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_q <= partial_max_q[addr];
		end
		if (cmd.upd_fire) begin
			partial_max_q[addr] <= new_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.upd_fire && completes) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd_fire && completes) begin
			pooled_q     <= new_val;
			orow_q       <= j_cur[IDX_BITS-1:0];
			ocol_q       <= k_cur[IDX_BITS-1:0];
			olast_map_q  <= jlast_q[ti] && klast_q[tk];
			olast_item_q <= !later_done;
		end
	end

	assign out_valid    = out_valid_q;
	assign pooled_max   = pooled_q;
	assign out_row      = orow_q;
	assign out_col      = ocol_q;
	assign last_in_map  = olast_map_q;
	assign last_of_item = olast_item_q;

endmodule
`default_nettype wire

// File: src/max_pool_2d_stream.sv
// a result is loaded into the output register by the update that completes its window
// each open window that the sample falls into takes a store read and a write, from the
// read-then-write of the one-port window store; a sample in no window takes neither
// 0 to 16 windows per sample, at most one when stride equals size
// reset: counters cleared, registers to width 256, height 256, stride 2, window 2
// the window store is not cleared; each slot is written at its window origin first
`default_nettype none
module max_pool_2d_stream #(
	parameter int MAX_WIDTH   = 256,
	parameter int MAX_HEIGHT  = 256,
	parameter int MAX_WINDOW  = 4,
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [mp2d_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [mp2d_pkg::CFG_DATA_W-1:0]   cfg_data,
	mp2d_in_if.sink                                in_ch,
	mp2d_out_if.source                             out_ch
);

	mp2d_pkg::cmd_t    cmd;
	mp2d_pkg::status_t st;
	logic              in_ready;

	mp2d_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.st       (st),
		.cmd      (cmd),
		.in_ready (in_ready)
	);

	mp2d_datapath #(
		.MAX_WIDTH   (MAX_WIDTH),
		.MAX_HEIGHT  (MAX_HEIGHT),
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data),
		.sample       (in_ch.sample),
		.cmd          (cmd),
		.st           (st),
		.out_ready    (out_ch.ready),
		.out_valid    (out_ch.valid),
		.pooled_max   (out_ch.pooled_max),
		.out_row      (out_ch.out_row),
		.out_col      (out_ch.out_col),
		.last_in_map  (out_ch.last_in_map),
		.last_of_item (out_ch.last_of_item)
	);

	assign in_ch.ready = in_ready;

	// a store read is always followed by its update phase
	a_read_then_update: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |=> !cmd.rd_en)
		else $error("store read issued twice in a row");

	// no new transaction while a store read is in flight
	a_no_accept_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> !cmd.rd_en)
		else $error("input transaction taken during store read");

	// a finished window is never dropped onto a full output register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd_fire && st.completes && st.out_full |-> out_ch.ready)
		else $error("result overwrote a pending output transaction");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd_fire && st.completes |=> out_ch.valid)
		else $error("completed window did not reach the output");

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`default_nettype none
module tb_top;

	localparam int CLK_HALF     = 6;
	localparam int RST_CYCLES   = 11;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 330;
	localparam int MAX_REPORTS  = 10;
	localparam int MAP_MAX      = 256;
	localparam int WIN_MAX      = 4;
	localparam int PHASE_CAP    = 80;

	typedef struct packed {
		logic signed [15:0] pooled_max;
		logic [7:0]         out_row;
		logic [7:0]         out_col;
		logic               last_in_map;
		logic               last_of_item;
	} pool_res_t;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	mp2d_pkg::cfg_reg_t              cfg_idx;
	logic [mp2d_pkg::CFG_DATA_W-1:0] cfg_data;

	mp2d_in_if #(.SAMPLE_BITS(16)) in_ch ();
	mp2d_out_if #(.SAMPLE_BITS(16)) out_ch ();

	max_pool_2d_stream DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	// pooling state as the block should hold it
	logic [8:0]         pm_width  = mp2d_pkg::RST_MAP_WIDTH;
	logic [8:0]         pm_height = mp2d_pkg::RST_MAP_HEIGHT;
	logic [2:0]         pm_stride = mp2d_pkg::RST_POOL_STRIDE;
	logic [2:0]         pm_window = mp2d_pkg::RST_WINDOW_SIZE;
	int unsigned        row_pos   = 0;
	int unsigned        col_pos   = 0;
	logic signed [15:0] win_max [WIN_MAX][MAP_MAX];

	pool_res_t pooled_q[$];
	int        err_cnt   = 0;
	int        cycle_cnt = 0;
	int        items_sent = 0;
	bit        calm = 0;

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic int unsigned clamp_cfg(int unsigned v, int unsigned hi);
		return (v < 1) ? 1 : ((v > hi) ? hi : v);
	endfunction

	task automatic set_pool_reg(input mp2d_pkg::cfg_reg_t idx, input logic [8:0] val);
		case (idx)
			mp2d_pkg::REG_MAP_WIDTH:   pm_width  = val;
			mp2d_pkg::REG_MAP_HEIGHT:  pm_height = val;
			mp2d_pkg::REG_POOL_STRIDE: pm_stride = val[2:0];
			mp2d_pkg::REG_WINDOW_SIZE: pm_window = val[2:0];
			default: ;
		endcase
		row_pos = 0;
		col_pos = 0;
	endtask

	task automatic predict_pooling(input logic signed [15:0] x);
		int unsigned w, h, s, ksz, oh, ow, r, c, j, k, jl, kl;
		int          ti, tk;
		pool_res_t   res[$];
		pool_res_t   one;
		w   = clamp_cfg(pm_width, MAP_MAX);
		h   = clamp_cfg(pm_height, MAP_MAX);
		s   = clamp_cfg(pm_stride, 4);
		ksz = clamp_cfg(pm_window, WIN_MAX);
		oh  = h / s;
		ow  = w / s;
		r   = (row_pos >= h) ? h - 1 : row_pos;
		c   = (col_pos >= w) ? w - 1 : col_pos;
		for (ti = WIN_MAX - 1; ti >= 0; ti--) begin
			if (ti > r / s) continue;
			j = r / s - ti;
			if (j >= oh || j * s + ksz - 1 < r) continue;
			for (tk = WIN_MAX - 1; tk >= 0; tk--) begin
				if (tk > c / s) continue;
				k = c / s - tk;
				if (k >= ow || k * s + ksz - 1 < c) continue;
				if (r == j * s && c == k * s)
					win_max[j % WIN_MAX][k] = x;
				else if (x > win_max[j % WIN_MAX][k])
					win_max[j % WIN_MAX][k] = x;
				jl = (j * s + ksz - 1 < h - 1) ? j * s + ksz - 1 : h - 1;
				kl = (k * s + ksz - 1 < w - 1) ? k * s + ksz - 1 : w - 1;
				if (r == jl && c == kl && res.size() < 16) begin
					one.pooled_max   = win_max[j % WIN_MAX][k];
					one.out_row      = 8'(j);
					one.out_col      = 8'(k);
					one.last_in_map  = (j == oh - 1 && k == ow - 1);
					one.last_of_item = 1'b0;
					res.push_back(one);
				end
			end
		end
		if (res.size() > 0)
			res[res.size() - 1].last_of_item = 1'b1;
		foreach (res[i])
			pooled_q.push_back(res[i]);
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h)
				r = 0;
		end
		row_pos = r;
		col_pos = c;
	endtask

	task automatic push_sample(input logic signed [15:0] x);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid  <= 1'b1;
		in_ch.sample <= x;
		do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
		predict_pooling(x);
		items_sent++;
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pooled_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input mp2d_pkg::cfg_reg_t idx, input logic [8:0] val);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		set_pool_reg(idx, val);
		@(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'($urandom_range(0, 3));
			default: return 16'($urandom);
		endcase
	endfunction

	// output side: random stalls, compare against oldest expected window
	initial begin
		int        hold;
		pool_res_t got;
		pool_res_t want;
		out_ch.ready = 1'b0;
		hold = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				got.pooled_max   = out_ch.pooled_max;
				got.out_row      = out_ch.out_row;
				got.out_col      = out_ch.out_col;
				got.last_in_map  = out_ch.last_in_map;
				got.last_of_item = out_ch.last_of_item;
				if (pooled_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= MAX_REPORTS)
						$display("unexpected transaction: max %0d row %0d col %0d lim %b loi %b",
							got.pooled_max, got.out_row, got.out_col,
							got.last_in_map, got.last_of_item);
				end else begin
					want = pooled_q.pop_front();
					if (got !== want) begin
						err_cnt++;
						if (err_cnt <= MAX_REPORTS)
							$display("mismatch: exp max %0d row %0d col %0d lim %b loi %b, %s",
								want.pooled_max, want.out_row, want.out_col,
								want.last_in_map, want.last_of_item,
								$sformatf("got max %0d row %0d col %0d lim %b loi %b",
									got.pooled_max, got.out_row, got.out_col,
									got.last_in_map, got.last_of_item));
					end
				end
				hold = calm ? 0 : $urandom_range(0, 4);
				if (hold > 0)
					out_ch.ready <= 1'b0;
			end else if (!out_ch.ready) begin
				if (hold > 0)
					hold--;
				if (hold == 0)
					out_ch.ready <= 1'b1;
			end
		end
	end

	// reset height, stride and window kept; only width shrunk
	task automatic test_reset_defaults();
		logic signed [15:0] vals [8];
		calm = 0;
		vals = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff,
			16'sh0100, 16'shff00, 16'sh5555, 16'shaaaa};
		write_reg(mp2d_pkg::REG_MAP_WIDTH, 9'd4);
		foreach (vals[i])
			push_sample(vals[i]);
		drain();
	endtask

	// stride 1, window 4: corner sample closes all sixteen clipped windows
	task automatic test_full_overlap();
		calm = 1;
		write_reg(mp2d_pkg::REG_MAP_WIDTH, 9'd4);
		write_reg(mp2d_pkg::REG_MAP_HEIGHT, 9'd4);
		write_reg(mp2d_pkg::REG_POOL_STRIDE, 9'd1);
		write_reg(mp2d_pkg::REG_WINDOW_SIZE, 9'd4);
		repeat (16) push_sample(rand_sample());
		drain();
	endtask

	// out of range values saturate, map with no output rows
	task automatic test_reg_saturation();
		calm = 0;
		write_reg(mp2d_pkg::REG_MAP_WIDTH, 9'd0);
		write_reg(mp2d_pkg::REG_MAP_HEIGHT, 9'd0);
		write_reg(mp2d_pkg::REG_POOL_STRIDE, 9'd0);
		write_reg(mp2d_pkg::REG_WINDOW_SIZE, 9'd7);
		push_sample(16'sh8000);
		push_sample(16'sh7fff);
		drain();
		write_reg(mp2d_pkg::REG_POOL_STRIDE, 9'd7);
		push_sample(16'sh1234);
		drain();
	endtask

	task automatic test_random_maps();
		int          n_items, map_sz, start;
		int unsigned wv, hv;
		logic [8:0]  w_raw, h_raw, s_raw, k_raw;
		bit          wrote;
		start = items_sent;
		// wide row, partial: width saturation without a full map
		calm = 0;
		write_reg(mp2d_pkg::REG_MAP_WIDTH, 9'($urandom_range(256, 511)));
		write_reg(mp2d_pkg::REG_MAP_HEIGHT, 9'd1);
		write_reg(mp2d_pkg::REG_POOL_STRIDE, 9'd1);
		write_reg(mp2d_pkg::REG_WINDOW_SIZE, 9'($urandom_range(0, 2)));
		repeat (40) push_sample(rand_sample());
		drain();
		while (items_sent < start + RANDOM_ITEMS) begin
			calm  = ($urandom_range(0, 3) == 0);
			w_raw = 9'($urandom_range(0, 9));
			h_raw = 9'($urandom_range(0, 9));
			if ($urandom_range(0, 7) == 0) begin
				w_raw = 9'($urandom_range(0, 2));
				h_raw = 9'($urandom_range(256, 511));
			end
			s_raw = {6'($urandom), 3'($urandom_range(0, 7))};
			k_raw = {6'($urandom), 3'($urandom_range(0, 7))};
			if ($urandom_range(0, 1) == 0) begin
				s_raw[8:3] = '0;
				k_raw[8:3] = '0;
			end
			wrote = 0;
			if ($urandom_range(0, 3) != 0) begin
				write_reg(mp2d_pkg::REG_MAP_WIDTH, w_raw);
				wrote = 1;
			end
			if ($urandom_range(0, 3) != 0) begin
				write_reg(mp2d_pkg::REG_MAP_HEIGHT, h_raw);
				wrote = 1;
			end
			if ($urandom_range(0, 3) != 0) begin
				write_reg(mp2d_pkg::REG_POOL_STRIDE, s_raw);
				wrote = 1;
			end
			if ($urandom_range(0, 3) != 0) begin
				write_reg(mp2d_pkg::REG_WINDOW_SIZE, k_raw);
				wrote = 1;
			end
			if (!wrote)
				write_reg(mp2d_pkg::REG_MAP_WIDTH, w_raw);
			wv     = clamp_cfg(pm_width, MAP_MAX);
			hv     = clamp_cfg(pm_height, MAP_MAX);
			map_sz = wv * hv;
			case ($urandom_range(0, 3))
				0: n_items = $urandom_range(1, map_sz);
				1: n_items = map_sz + $urandom_range(1, map_sz);
				default: n_items = map_sz;
			endcase
			if (n_items > PHASE_CAP)
				n_items = PHASE_CAP;
			repeat (n_items) push_sample(rand_sample());
			drain();
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_idx      = mp2d_pkg::REG_MAP_WIDTH;
		cfg_data     = '0;
		in_ch.valid  = 1'b0;
		in_ch.sample = '0;
		repeat (RST_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_full_overlap();
		test_reg_saturation();
		test_random_maps();
		drain();
		if (err_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
`default_nettype wire

// File: max_pool_2d_stream.f
src/mp2d_pkg.sv
src/mp2d_if.sv
src/mp2d_ctrl.sv
src/mp2d_datapath.sv
src/max_pool_2d_stream.sv
tb/tb_top.sv
